>>> rtl/dnle_pkg.sv
`timescale 1ns / 1ps

package dnle_pkg;

  // Label count width: holds any label length up to 62
  localparam int CNT_W = 6;

  // Input mode codes
  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_END  = 1'b1;

  // Character constants
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_UP_A     = 8'h41;
  localparam logic [7:0] CH_UP_Z     = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // One beat offered by the sequencer to the output register
  typedef struct packed {
    logic       vld;
    logic [7:0] wbyte;
    logic       last;
    logic       err;
  } emit_t;

  // Fold an upper-case ASCII letter to lower case
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

>>> rtl/dnle_store.sv
`timescale 1ns / 1ps

module dnle_store #(
  parameter int DEPTH  = 62,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  // Write one label octet
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/dnle_ctrl.sv
`timescale 1ns / 1ps

module dnle_ctrl
  import dnle_pkg::*;
#(
  parameter int LABEL_MAX = 62,
  parameter int ADDR_W    = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [7:0]        ch,
  input  logic              out_free,
  output emit_t             emit,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LEN  = 6'b000010,
    S_RD   = 6'b000100,
    S_DATA = 6'b001000,
    S_TERM = 6'b010000,
    S_ERR  = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             overflow, overflow_next;
  logic             term_pending, term_pending_next;
  logic             in_accept;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && (state == S_IDLE);

  // Store port: write in idle, read one octet ahead of each data beat
  assign wr_addr = count[ADDR_W-1:0];
  assign wr_data = fold_case(ch);
  assign rd_en   = (state == S_RD);
  assign rd_addr = idx[ADDR_W-1:0];

  // Sequence one name item
  always_comb begin
    state_next        = state;
    count_next        = count;
    idx_next          = idx;
    overflow_next     = overflow;
    term_pending_next = term_pending;
    wr_en             = 1'b0;
    emit              = '0;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (mode == MODE_END) begin
            term_pending_next = 1'b1;
            idx_next          = '0;
            state_next        = (count != '0) ? S_LEN : S_TERM;
          end else if (ch == CH_DOT) begin
            term_pending_next = 1'b0;
            idx_next          = '0;
            state_next        = (count != '0) ? S_LEN : S_ERR;
          end else if (count < CNT_W'(LABEL_MAX)) begin
            wr_en      = 1'b1;
            count_next = count + 1'b1;
          end else begin
            overflow_next = 1'b1;
          end
        end
      end
      S_LEN: begin
        emit.vld   = 1'b1;
        emit.wbyte = 8'(count);
        emit.err   = overflow;
        if (out_free) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = S_DATA;
      end
      S_DATA: begin
        emit.vld   = 1'b1;
        emit.wbyte = rd_data;
        emit.err   = overflow;
        if (out_free) begin
          idx_next = idx + 1'b1;
          if (idx + 1'b1 == count) begin
            count_next    = '0;
            overflow_next = 1'b0;
            state_next    = term_pending ? S_TERM : S_IDLE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_TERM: begin
        emit.vld  = 1'b1;
        emit.last = 1'b1;
        if (out_free) begin
          count_next        = '0;
          overflow_next     = 1'b0;
          term_pending_next = 1'b0;
          state_next        = S_IDLE;
        end
      end
      S_ERR: begin
        emit.vld = 1'b1;
        emit.err = 1'b1;
        if (out_free) begin
          overflow_next = 1'b0;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      idx          <= '0;
      overflow     <= 1'b0;
      term_pending <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      idx          <= idx_next;
      overflow     <= overflow_next;
      term_pending <= term_pending_next;
    end
  end

endmodule

>>> rtl/dns_name_label_encoder.sv
`timescale 1ns / 1ps

// DNS name label encoder: takes a dotted name one character per beat and
// emits it in DNS wire format, one octet per output beat, with letters
// folded to lower case. Character beats never stall the input. A dot or
// end beat holds the input stalled while the label is flushed: first the
// length octet, then each label octet, each read back through the single
// registered read port of the label store, then the terminator on an end
// beat; output stalls add to this. Labels longer than LABEL_MAX are cut
// and flagged with error on all their octets; an empty interior label
// yields one zero octet with error. The final terminator carries last.
module dns_name_label_encoder
  import dnle_pkg::*;
#(
  parameter int LABEL_MAX = 62
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] wire_byte,
  output logic       last,
  output logic       error
);

  localparam int ADDR_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

  emit_t             emit;
  logic              out_free;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  assign out_free = !out_valid || !out_stall;

  dnle_ctrl #(
    .LABEL_MAX (LABEL_MAX),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .ch       (ch),
    .out_free (out_free),
    .emit     (emit),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  dnle_store #(
    .DEPTH  (LABEL_MAX),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Hold the output beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit.vld) begin
      wire_byte <= emit.wbyte;
      last      <= emit.last;
      error     <= emit.err;
    end
  end

endmodule

>>> bench/tb_dns_name_label_encoder.sv
`timescale 1ns / 1ps

module tb_dns_name_label_encoder;
  import dnle_pkg::*;

  localparam int LABEL_MAX = 62;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int IDLE_PCT = 38;
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int CALM_FROM = 260;
  localparam int CALM_TO = 340;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic       mode;
    logic [7:0] ch;
  } name_beat_t;

  typedef struct packed {
    logic [7:0] wbyte;
    logic       last;
    logic       err;
  } octet_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       mode = MODE_CHAR;
  logic [7:0] ch = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] wire_byte;
  logic       last;
  logic       error;

  name_beat_t pend_q[$];
  octet_t     octet_q[$];

  // Predictor state: buffered label and its flags
  logic [7:0] label_buf[LABEL_MAX];
  int         lab_len = 0;
  logic       lab_cut = 1'b0;

  int  fails = 0;
  int  cycles = 0;
  int  taken_cnt = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  logic calm;

  string host_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-";

  assign calm = (taken_cnt >= CALM_FROM) && (taken_cnt < CALM_TO);

  dns_name_label_encoder #(
    .LABEL_MAX(LABEL_MAX)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .ch        (ch),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .wire_byte (wire_byte),
    .last      (last),
    .error     (error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Append one expected octet
  task automatic add_octet(input octet_t o);
    octet_q.insert(octet_q.size(), o);
  endtask

  // Append one pending name beat
  task automatic add_beat(input name_beat_t b);
    pend_q.insert(pend_q.size(), b);
  endtask

  // Emit length octet and buffered octets of the current label, then clear it
  task automatic emit_label();
    add_octet(octet_t'{wbyte: 8'(lab_len), last: 1'b0, err: lab_cut});
    for (int i = 0; i < lab_len; i++) begin
      add_octet(octet_t'{wbyte: label_buf[i], last: 1'b0, err: lab_cut});
    end
    lab_len = 0;
    lab_cut = 1'b0;
  endtask

  // Work out the wire octets caused by one accepted name beat
  task automatic encode_beat(input logic m, input logic [7:0] c);
    logic [7:0] low;
    if (m == MODE_END) begin
      if (lab_len != 0) begin
        emit_label();
      end
      add_octet(octet_t'{wbyte: 8'h00, last: 1'b1, err: 1'b0});
      lab_len = 0;
      lab_cut = 1'b0;
    end else if (c == CH_DOT) begin
      if (lab_len == 0) begin
        // empty interior label: lone zero octet, flagged
        add_octet(octet_t'{wbyte: 8'h00, last: 1'b0, err: 1'b1});
        lab_cut = 1'b0;
      end else begin
        emit_label();
      end
    end else if (lab_len < LABEL_MAX) begin
      low = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFFSET : c;
      label_buf[lab_len] = low;
      lab_len++;
    end else begin
      // drop surplus character, mark the label truncated
      lab_cut = 1'b1;
    end
  endtask

  task automatic note_mismatch(input string what, input octet_t want, input octet_t got);
    fails++;
    if (fails <= 10) begin
      $display("%0t %s: expected byte=%h last=%b error=%b, got byte=%h last=%b error=%b",
               $realtime, what, want.wbyte, want.last, want.err,
               got.wbyte, got.last, got.err);
    end
  endtask

  task automatic push_char(input logic [7:0] c);
    add_beat(name_beat_t'{mode: MODE_CHAR, ch: c});
  endtask

  task automatic push_end();
    add_beat(name_beat_t'{mode: MODE_END, ch: 8'($urandom_range(255))});
  endtask

  task automatic queue_label(input int len);
    for (int i = 0; i < len; i++) begin
      push_char(host_chars[$urandom_range(host_chars.len() - 1)]);
    end
  endtask

  function automatic int pick_label_len();
    if ($urandom_range(11) == 0) begin
      return $urandom_range(68, 55);
    end
    return $urandom_range(10, 1);
  endfunction

  // Sender: offer a new beat only after the previous one was taken
  always @(posedge clk) begin
    name_beat_t nb;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pend_q.size() != 0 &&
          (calm || hold_left != 0 || $urandom_range(99) >= IDLE_PCT)) begin
        nb = pend_q.pop_front();
        in_valid <= 1'b1;
        mode <= nb.mode;
        ch <= nb.ch;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && taken_cnt >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Monitor: predict on accepted input beats, check accepted output beats
  always @(posedge clk) begin : mon
    octet_t got;
    octet_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        encode_beat(mode, ch);
        taken_cnt <= taken_cnt + 1;
      end
      if (out_valid && !out_stall) begin
        got = '{wbyte: wire_byte, last: last, err: error};
        if (octet_q.size() == 0) begin
          note_mismatch("unexpected octet", '0, got);
        end else begin
          want = octet_q.pop_front();
          if (got !== want) begin
            note_mismatch("octet mismatch", want, got);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_dns_name_label_encoder: FAIL");
      $finish;
    end
  end

  initial begin
    int r;
    int nl;
    int len;
    bit broken;

    // Directed: empty name, leading dot, case edges, byte extremes, double dot,
    // trailing dot, end carrying a dot character
    push_end();
    push_char(CH_DOT);
    push_end();
    push_char(CH_UP_A);
    push_char(CH_UP_Z);
    push_char(CH_UP_A - 8'd1);
    push_char(CH_UP_Z + 8'd1);
    push_char(8'h00);
    push_char(8'hFF);
    push_char(CH_DOT);
    push_char(CH_DOT);
    push_char("x");
    push_end();
    push_char("Q");
    push_char(CH_DOT);
    push_end();
    push_char("b");
    add_beat(name_beat_t'{mode: MODE_END, ch: CH_DOT});

    // Full-length label, then an overlong one
    queue_label(LABEL_MAX);
    push_char(CH_DOT);
    queue_label(LABEL_MAX + 4);
    push_end();

    // Random names: mostly well formed, some with empty labels, some noise
    while (pend_q.size() < 460) begin
      r = $urandom_range(99);
      if (r < 85) begin
        broken = (r >= 70);
        nl = $urandom_range(4, 1);
        if (broken && (nl == 1 || $urandom_range(1) == 0)) begin
          push_char(CH_DOT);
        end
        for (int k = 0; k < nl; k++) begin
          queue_label(pick_label_len());
          if (k < nl - 1) begin
            push_char(CH_DOT);
            if (broken && $urandom_range(2) == 0) begin
              push_char(CH_DOT);
            end
          end
        end
        if ($urandom_range(9) == 0) begin
          push_char(CH_DOT);
        end
        push_end();
      end else begin
        len = $urandom_range(12, 1);
        repeat (len) push_char(8'($urandom_range(255)));
        push_end();
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Drain: all beats taken, all octets seen, then a quiet tail
    while (pend_q.size() != 0 || in_valid) @(posedge clk);
    while (octet_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("tb_dns_name_label_encoder: PASS");
    end else begin
      $display("tb_dns_name_label_encoder: FAIL");
    end
    $finish;
  end

endmodule
